// ===== hdl/ucodec_pkg.sv =====
// Shared types, constants and character functions for the URL percent codec.
package ucodec_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] PctMark   = 8'h25;
  localparam logic [7:0] UnderMark = 8'h5F;
  localparam logic [7:0] PlusMark  = 8'h2B;
  localparam logic [7:0] DashMark  = 8'h2D;
  localparam logic [7:0] DotMark   = 8'h2E;
  localparam logic [7:0] DigitBase = 8'h30;
  localparam logic [7:0] AlphaBase = 8'h37;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_SINGLE,
    CMD_ESCAPE,
    CMD_PCT_RAW
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  function automatic logic pass_through(input logic [7:0] c);
    logic ok;
    ok = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
         ((c >= 8'h61) && (c <= 8'h7A)) || (c == UnderMark) || (c == PlusMark) ||
         (c == DashMark) || (c == DotMark);
    return ok;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    logic [7:0] r;
    r = (n <= 4'd9) ? ({4'h0, n} + DigitBase) : ({4'h0, n} + AlphaBase);
    return r;
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h41 + 8'd10;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h61 + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

// ===== hdl/ucodec_front.sv =====
// Front end: holds the mode and escape state, classifies bytes into commands.
module ucodec_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 accept_i,
  input  ucodec_pkg::in_item_t item_i,
  output logic                 cmd_push_o,
  output ucodec_pkg::cmd_t     cmd_o
);

  logic       mode_q, mode_d;
  logic [1:0] held_count_q, held_count_d;
  logic [7:0] held_digit_q, held_digit_d;

  always_comb begin
    mode_d       = mode_q;
    held_count_d = held_count_q;
    held_digit_d = held_digit_q;
    cmd_push_o   = 1'b0;
    cmd_o.kind   = ucodec_pkg::CMD_SINGLE;
    cmd_o.data   = item_i.in_byte;
    cmd_o.last   = item_i.in_last;
    if (cfg_we_i) begin
      mode_d       = cfg_wdata_i;
      held_count_d = 2'd0;
      held_digit_d = 8'h00;
    end else if (accept_i) begin
      if (mode_q == ucodec_pkg::ModeEncode) begin
        held_count_d = 2'd0;
        held_digit_d = 8'h00;
        cmd_push_o   = 1'b1;
        cmd_o.kind   = ucodec_pkg::pass_through(item_i.in_byte) ?
                       ucodec_pkg::CMD_SINGLE : ucodec_pkg::CMD_ESCAPE;
      end else if (held_count_q == 2'd1) begin
        if (item_i.in_last) begin
          held_count_d = 2'd0;
          cmd_push_o   = 1'b1;
          cmd_o.kind   = ucodec_pkg::CMD_PCT_RAW;
        end else begin
          held_digit_d = item_i.in_byte;
          held_count_d = 2'd2;
        end
      end else if (held_count_q == 2'd2) begin
        held_count_d = 2'd0;
        held_digit_d = 8'h00;
        cmd_push_o   = 1'b1;
        cmd_o.data   = {ucodec_pkg::digit_value(held_digit_q),
                        ucodec_pkg::digit_value(item_i.in_byte)};
      end else begin
        held_count_d = 2'd0;
        if ((item_i.in_byte == ucodec_pkg::PctMark) && !item_i.in_last) begin
          held_count_d = 2'd1;
        end else begin
          cmd_push_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ucodec_pkg::ModeEncode;
      held_count_q <= 2'd0;
      held_digit_q <= 8'h00;
    end else begin
      mode_q       <= mode_d;
      held_count_q <= held_count_d;
      held_digit_q <= held_digit_d;
    end
  end

endmodule

// ===== hdl/ucodec_fifo.sv =====
// Short command queue between the front end and the back end.
module ucodec_fifo #(
  parameter int unsigned Depth = ucodec_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ucodec_pkg::cmd_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output ucodec_pkg::cmd_t data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ucodec_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hdl/ucodec_back.sv =====
// Back end: expands one command into output bytes into the result register.
module ucodec_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_empty_i,
  input  ucodec_pkg::cmd_t      cmd_i,
  output logic                  cmd_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output ucodec_pkg::out_item_t out_item_o
);

  logic                  out_valid_q, out_valid_d;
  ucodec_pkg::out_item_t out_q, out_d;
  logic [1:0]            step_q, step_d;
  logic                  load, fire, final_step;

  assign load  = !out_valid_q || pop_i;
  assign fire  = load && !cmd_empty_i;

  always_comb begin
    out_d      = out_q;
    final_step = 1'b1;
    unique case (cmd_i.kind)
      ucodec_pkg::CMD_ESCAPE: begin
        final_step = (step_q == 2'd2);
        if (step_q == 2'd0) begin
          out_d.out_byte = ucodec_pkg::PctMark;
        end else if (step_q == 2'd1) begin
          out_d.out_byte = ucodec_pkg::nibble_char(cmd_i.data[7:4]);
        end else begin
          out_d.out_byte = ucodec_pkg::nibble_char(cmd_i.data[3:0]);
        end
      end
      ucodec_pkg::CMD_PCT_RAW: begin
        final_step     = (step_q == 2'd1);
        out_d.out_byte = (step_q == 2'd0) ? ucodec_pkg::PctMark : cmd_i.data;
      end
      default: begin
        out_d.out_byte = cmd_i.data;
      end
    endcase
    out_d.out_last = final_step && cmd_i.last;
    if (!fire) begin
      out_d = out_q;
    end
    step_d      = fire ? (final_step ? 2'd0 : step_q + 2'd1) : step_q;
    out_valid_d = load ? !cmd_empty_i : out_valid_q;
  end

  assign cmd_pop_o  = fire && final_step;
  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

endmodule

// ===== hdl/url_percent_codec.sv =====
// Top level of the streaming URL percent encoder and decoder.
//
//   Channel   Ports                       Transfer when
//   input     push, full, in_item_i       push && !full
//   result    empty, pop, out_item_o      pop && !empty
//   config    cfg_we_i, cfg_wdata_i       cfg_we_i
//
// One input byte is taken per cycle while the command queue has room.
// The back end sends one output byte per cycle while the result side keeps popping,
// so an escaped byte in encode mode occupies it for three output bytes; a result
// passes through the command queue and then the result register after its input
// transfer. Reset clears the mode to encode, the escape state, the queue and the
// result register. Either side may stall at any time without loss.
module url_percent_codec #(
  parameter int unsigned QueueDepth = ucodec_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  ucodec_pkg::in_item_t  in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output ucodec_pkg::out_item_t out_item_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i
);

  ucodec_pkg::cmd_t front_cmd, back_cmd;
  logic             cmd_push, cmd_pop, cmd_empty;

  ucodec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (push && !full),
    .item_i      (in_item_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (front_cmd)
  );

  ucodec_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  ucodec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== hdl/ucodec_checker.sv =====
// Port-level checker for the URL percent codec and its bind statement.
module ucodec_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  push,
  input logic                  full,
  input ucodec_pkg::in_item_t  in_item_i,
  input logic                  empty,
  input logic                  pop,
  input ucodec_pkg::out_item_t out_item_o,
  input logic                  cfg_we_i,
  input logic                  cfg_wdata_i
);

  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ucodec_pkg::ModeEncode;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // A waiting result stays put until it is taken.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result changed while stalled");

  // Every encoded byte yields a result once it has passed the queue and the result register.
  a_encode_yields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && !cfg_we_i && mode_q == ucodec_pkg::ModeEncode) |=> ##1 !empty)
    else $error("encode transfer produced no result");

  // Encode output consists only of safe characters and percent marks.
  a_encode_charset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && mode_q == ucodec_pkg::ModeEncode) |->
    (ucodec_pkg::pass_through(out_item_o.out_byte) ||
     out_item_o.out_byte == ucodec_pkg::PctMark))
    else $error("encode produced an unsafe character");

  // In encode mode a percent mark always opens an escape and never ends a string.
  a_encode_no_last_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.out_last && out_item_o.out_byte == ucodec_pkg::PctMark) |->
    (mode_q == ucodec_pkg::ModeDecode))
    else $error("encode ended a string on a percent mark");

endmodule

bind url_percent_codec ucodec_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .in_item_i   (in_item_i),
  .empty       (empty),
  .pop         (pop),
  .out_item_o  (out_item_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i)
);

// ===== sim/url_percent_codec_tb.sv =====
// Self-checking testbench for the URL percent codec: directed table, then random strings.
`timescale 1ns / 1ps

module url_percent_codec_tb;

  typedef struct packed {
    logic                             typed;
    logic [1:0]                       n;
    ucodec_pkg::out_item_t [2:0]      r;
  } conv_out_t;

  typedef enum logic {
    ROW_BYTE,
    ROW_MODE
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    ucodec_pkg::in_item_t item;
    conv_out_t            want;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  ucodec_pkg::in_item_t  in_item;
  logic                  empty;
  logic                  pop;
  ucodec_pkg::out_item_t out_item;
  logic                  cfg_we;
  logic                  cfg_wdata;

  logic       model_mode;
  logic [1:0] model_held_n;
  logic [7:0] model_held_byte;

  ucodec_pkg::out_item_t pending_out[$];
  conv_out_t             row_want_q[$];
  dir_row_t              dir_rows[$];
  int unsigned           errors;
  int unsigned           items_sent;
  int unsigned           items_taken;
  int unsigned           results_seen;
  int unsigned           mode_writes;
  bit                    calm;

  url_percent_codec u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic is_plain(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) || (c == ucodec_pkg::UnderMark) ||
           (c == ucodec_pkg::PlusMark) || (c == ucodec_pkg::DashMark) ||
           (c == ucodec_pkg::DotMark);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (ucodec_pkg::DigitBase + 8'(n)) : (ucodec_pkg::AlphaBase + 8'(n));
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

  function automatic conv_out_t codec_next(input ucodec_pkg::in_item_t it);
    conv_out_t  o;
    logic [7:0] c;
    o = '0;
    c = it.in_byte;
    if (model_mode == ucodec_pkg::ModeEncode) begin
      model_held_n    = 2'd0;
      model_held_byte = 8'h00;
      if (is_plain(c)) begin
        o.n = 2'd1;
        o.r[0].out_byte = c;
        o.r[0].out_last = it.in_last;
      end else begin
        o.n = 2'd3;
        o.r[0].out_byte = ucodec_pkg::PctMark;
        o.r[1].out_byte = hex_char(c[7:4]);
        o.r[2].out_byte = hex_char(c[3:0]);
        o.r[2].out_last = it.in_last;
      end
    end else if (model_held_n == 2'd1) begin
      if (it.in_last) begin
        model_held_n = 2'd0;
        o.n = 2'd2;
        o.r[0].out_byte = ucodec_pkg::PctMark;
        o.r[1].out_byte = c;
        o.r[1].out_last = 1'b1;
      end else begin
        model_held_byte = c;
        model_held_n    = 2'd2;
      end
    end else if (model_held_n == 2'd2) begin
      model_held_n = 2'd0;
      o.n = 2'd1;
      o.r[0].out_byte = {hex_value(model_held_byte), hex_value(c)};
      o.r[0].out_last = it.in_last;
      model_held_byte = 8'h00;
    end else begin
      model_held_n = 2'd0;
      if ((c == ucodec_pkg::PctMark) && !it.in_last) begin
        model_held_n = 2'd1;
      end else begin
        o.n = 2'd1;
        o.r[0].out_byte = c;
        o.r[0].out_last = it.in_last;
      end
    end
    return o;
  endfunction

  function automatic void add_row(input row_kind_e k, input logic [7:0] b, input logic l,
                                  input int tn, input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2);
    dir_row_t row;
    row = '0;
    row.kind = k;
    row.item.in_byte = b;
    row.item.in_last = l;
    if (tn >= 0) begin
      row.want.typed = 1'b1;
      row.want.n = 2'(tn);
      row.want.r[0].out_byte = b0;
      row.want.r[1].out_byte = b1;
      row.want.r[2].out_byte = b2;
      if (tn > 0) begin
        row.want.r[tn - 1].out_last = l;
      end
    end
    dir_rows.push_back(row);
  endfunction

  function automatic logic [7:0] rand_hex();
    int unsigned k;
    k = $urandom_range(0, 21);
    if (k < 10) begin
      return 8'h30 + 8'(k);
    end else if (k < 16) begin
      return 8'h37 + 8'(k);
    end
    return 8'h57 + 8'(k - 6);
  endfunction

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 5))
      0, 1: return 8'($urandom_range(0, 255));
      2: return 8'h61 + 8'($urandom_range(0, 25));
      3: return rand_hex();
      4: begin
        case ($urandom_range(0, 3))
          0: return ucodec_pkg::UnderMark;
          1: return ucodec_pkg::PlusMark;
          2: return ucodec_pkg::DashMark;
          default: return ucodec_pkg::DotMark;
        endcase
      end
      default: return ucodec_pkg::PctMark;
    endcase
  endfunction

  task automatic send_byte(input ucodec_pkg::in_item_t it, input conv_out_t want);
    int unsigned gap;
    if (!calm && ($urandom_range(0, 5) == 0)) begin
      gap = $urandom_range(1, 7);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    row_want_q.push_back(want);
    push    <= 1'b1;
    in_item <= it;
    do begin
      @(posedge clk_i);
    end while (full !== 1'b0);
    items_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_out.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    wait_drained();
    repeat (10) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    mode_writes++;
  endtask

  task automatic send_string(input logic well_formed, input int unsigned len);
    logic [7:0]           s[$];
    ucodec_pkg::in_item_t it;
    int unsigned          k;
    while (s.size() < len) begin
      if (well_formed && (len - s.size() >= 3) && ($urandom_range(0, 2) == 0)) begin
        s.push_back(ucodec_pkg::PctMark);
        s.push_back(rand_hex());
        s.push_back(rand_hex());
      end else begin
        s.push_back(rand_char());
      end
    end
    for (k = 0; k < s.size(); k++) begin
      it.in_byte = s[k];
      it.in_last = (k == s.size() - 1);
      send_byte(it, '0);
    end
  endtask

  always @(posedge clk_i) begin : monitor_blk
    conv_out_t             got;
    conv_out_t             want;
    ucodec_pkg::out_item_t e;
    int                    i;
    if (rst_ni) begin
      if (cfg_we) begin
        model_mode      = cfg_wdata;
        model_held_n    = 2'd0;
        model_held_byte = 8'h00;
      end
      if (push && !full) begin
        got  = codec_next(in_item);
        want = got;
        if (row_want_q.size() != 0) begin
          want = row_want_q.pop_front();
          if (!want.typed) want = got;
        end
        for (i = 0; i < int'(want.n); i++) pending_out.push_back(want.r[i]);
        items_taken++;
      end
      if (pop && !empty) begin
        results_seen++;
        if (pending_out.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual byte %h last %b",
                   $realtime, out_item.out_byte, out_item.out_last);
        end else begin
          e = pending_out.pop_front();
          if ((out_item.out_byte !== e.out_byte) || (out_item.out_last !== e.out_last)) begin
            errors++;
            $display("%0t: mismatch, expected byte %h last %b, actual byte %h last %b",
                     $realtime, e.out_byte, e.out_last, out_item.out_byte, out_item.out_last);
          end
        end
      end
    end
  end

  initial begin : result_side
    int unsigned hold;
    hold = 0;
    pop  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (calm) begin
        pop <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 7) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    #5ms;
    $display("FAIL url_percent_codec");
    $finish;
  end

  initial begin : stimulus
    int unsigned p;
    int unsigned start_cnt;
    int unsigned k;
    bit          paused;
    logic        m;
    rst_ni          = 1'b0;
    push            = 1'b0;
    in_item         = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = ucodec_pkg::ModeEncode;
    model_mode      = ucodec_pkg::ModeEncode;
    model_held_n    = 2'd0;
    model_held_byte = 8'h00;
    errors          = 0;
    items_sent      = 0;
    items_taken     = 0;
    results_seen    = 0;
    mode_writes     = 0;
    calm            = 1'b0;
    paused          = 1'b0;

    add_row(ROW_BYTE, 8'h41, 1'b0, 1, 8'h41, 8'h00, 8'h00);
    add_row(ROW_BYTE, 8'h00, 1'b0, 3, ucodec_pkg::PctMark, 8'h30, 8'h30);
    add_row(ROW_BYTE, 8'hFF, 1'b1, 3, ucodec_pkg::PctMark, 8'h46, 8'h46);
    add_row(ROW_BYTE, ucodec_pkg::UnderMark, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, ucodec_pkg::PlusMark, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, ucodec_pkg::DashMark, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, ucodec_pkg::DotMark, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, ucodec_pkg::PctMark, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, 8'h7A, 1'b1, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_MODE, {7'd0, ucodec_pkg::ModeDecode}, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, ucodec_pkg::PctMark, 1'b0, 0, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, 8'h34, 1'b0, 0, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, 8'h31, 1'b1, 1, 8'h41, 8'h00, 8'h00);
    add_row(ROW_BYTE, ucodec_pkg::PctMark, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, 8'h66, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, 8'h46, 1'b0, 1, 8'hFF, 8'h00, 8'h00);
    add_row(ROW_BYTE, ucodec_pkg::PctMark, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, 8'h47, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, 8'h7A, 1'b1, 1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, ucodec_pkg::PctMark, 1'b1, 1, ucodec_pkg::PctMark, 8'h00, 8'h00);
    add_row(ROW_BYTE, ucodec_pkg::PctMark, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, 8'h78, 1'b1, 2, ucodec_pkg::PctMark, 8'h78, 8'h00);
    add_row(ROW_BYTE, 8'hFF, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, ucodec_pkg::PctMark, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, 8'h34, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_MODE, {7'd0, ucodec_pkg::ModeDecode}, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, 8'h34, 1'b0, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_BYTE, 8'h31, 1'b1, -1, 8'h00, 8'h00, 8'h00);
    add_row(ROW_MODE, {7'd0, ucodec_pkg::ModeEncode}, 1'b0, -1, 8'h00, 8'h00, 8'h00);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < dir_rows.size(); k++) begin
      if (dir_rows[k].kind == ROW_MODE) begin
        write_mode(dir_rows[k].item.in_byte[0]);
      end else begin
        send_byte(dir_rows[k].item, dir_rows[k].want);
      end
    end

    for (p = 0; p < 8; p++) begin
      if (p == 7) calm = 1'b1;
      m = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
      write_mode(m);
      start_cnt = items_sent;
      while (items_sent - start_cnt < 35) begin
        send_string((m == ucodec_pkg::ModeDecode) && ($urandom_range(0, 3) != 0),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 9));
        if ((p == 2) && !paused && (items_sent - start_cnt >= 20)) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d input transfers and %0d result transfers across %0d mode writes,",
             items_taken, results_seen, mode_writes);
    $display("with directed escapes, short escapes, dropped held bytes and random strings.");
    if (errors == 0) begin
      $display("PASS url_percent_codec");
    end else begin
      $display("FAIL url_percent_codec");
    end
    $finish;
  end

endmodule
